>>> sv/ntc_pkg.sv
// ----------------------------------------------------------------------------
// ntc_pkg: shared types and constants of the NTC thermistor core
// Status codes, register indexes, state encodings and datapath widths.
// ----------------------------------------------------------------------------
package ntc_pkg;

  // result status codes
  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_DISABLED    = 3'd1,
    STAT_NO_DATA     = 3'd2,
    STAT_NEAR_SUPPLY = 3'd3,
    STAT_NEAR_GROUND = 3'd4
  } status_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_ENABLED      = 3'd0,
    REG_BURST_LEN    = 3'd1,
    REG_SUPPLY_MV    = 3'd2,
    REG_FIXED_OHMS   = 3'd3,
    REG_NOMINAL_OHMS = 3'd4,
    REG_BETA         = 3'd5
  } cfg_reg_t;

  localparam int CFG_DATA_W = 20;

  // serial divider widths
  localparam int DIV_NUM_W = 61;
  localparam int DIV_DEN_W = 47;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  // log2 unit widths: input below 2^33, result Q24 with a 6-bit exponent
  localparam int LOG_IN_W  = 33;
  localparam int LOG_OUT_W = 30;
  localparam int LOG_M_W   = 31;
  localparam int LOG_S_W   = 6;

  // ln(2) in Q32
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // B-equation constants
  localparam int B_SCALE_DEN = 100;
  localparam int T0_CENTI_B  = 29815;
  localparam int B_SCALE_NUM = 2981500;
  localparam int KELVIN_CENTI = 27315;
  localparam int TEMP_MAX_Q  = 27315 + 32767;

  // shared unit handshake status
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

  typedef enum logic [1:0] {
    LOG_IDLE,
    LOG_NORM,
    LOG_SQUARE
  } log_state_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_MV_PREP,
    ST_MV_GO,
    ST_MV_WAIT,
    ST_CHECK,
    ST_LOGA_GO,
    ST_LOGA_WAIT,
    ST_LOGB_GO,
    ST_LOGB_WAIT,
    ST_LN,
    ST_LMUL,
    ST_DEN,
    ST_NUM,
    ST_T_GO,
    ST_T_WAIT,
    ST_OUT
  } ctrl_state_t;

endpackage

>>> sv/ntc_if.sv
// ----------------------------------------------------------------------------
// ntc_if: sample and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ntc_in_if #(parameter int ADC_BITS = 12);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] sample;
  logic                read_ok;

  modport source (output valid, output sample, output read_ok, input ready);
  modport sink   (input valid, input sample, input read_ok, output ready);
endinterface

interface ntc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [12:0] millivolts;
  logic signed [15:0] temperature_centi;

  modport source (output valid, output status, output millivolts,
                  output temperature_centi, input ready);
  modport sink   (input valid, input status, input millivolts,
                  input temperature_centi, output ready);
endinterface

>>> sv/ntc_div.sv
// ----------------------------------------------------------------------------
// ntc_div: bit-serial restoring divider
// One quotient bit per cycle over the full numerator width.
// ----------------------------------------------------------------------------
module ntc_div
  import ntc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output unit_status_t         stat,
  output logic [DIV_NUM_W-1:0] quo
);

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_NUM_W-1:0] nsh;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  // trial subtract of one shifted-in numerator bit
  always_comb begin
    trial = {rem, nsh[DIV_NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rem   <= '0;
      den_r <= den;
      nsh   <= num;
      quo   <= '0;
    end else if (busy) begin
      rem <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      nsh <= {nsh[DIV_NUM_W-2:0], 1'b0};
      quo <= {quo[DIV_NUM_W-2:0], ge};
    end
  end

  assign stat = '{busy: busy, done: done};

endmodule

>>> sv/ntc_log2.sv
// ----------------------------------------------------------------------------
// ntc_log2: serial log2 in Q24
// Normalizes by one-bit shifts, then finds one fraction bit per squaring.
// ----------------------------------------------------------------------------
module ntc_log2
  import ntc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [LOG_IN_W-1:0]  x,
  output unit_status_t         stat,
  output logic [LOG_OUT_W-1:0] result
);

  log_state_t           state;
  log_state_t           state_next;
  logic [LOG_IN_W-1:0]  w;
  logic [LOG_S_W-1:0]   s;
  logic [LOG_M_W-1:0]   m;
  logic [4:0]           bit_idx;
  logic                 done;
  logic                 busy;
  logic [2*LOG_M_W-1:0] sq;
  logic [LOG_M_W:0]     t;

  // square of the mantissa, back to Q30
  always_comb begin
    sq = (2*LOG_M_W)'(m) * (2*LOG_M_W)'(m);
    t  = sq[2*LOG_M_W-1:LOG_M_W-1];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      LOG_IDLE:   if (start) state_next = LOG_NORM;
      LOG_NORM:   if (w[LOG_IN_W-1]) state_next = LOG_SQUARE;
      LOG_SQUARE: if (bit_idx == 5'd0) state_next = LOG_IDLE;
      default:    state_next = LOG_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy = (state != LOG_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOG_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == LOG_SQUARE) && (bit_idx == 5'd0);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      LOG_IDLE: begin
        if (start) begin
          w <= (x == '0) ? LOG_IN_W'(1) : x;
          s <= '0;
        end
      end
      LOG_NORM: begin
        if (w[LOG_IN_W-1]) begin
          m       <= w[LOG_IN_W-1 -: LOG_M_W];
          result  <= {LOG_S_W'(LOG_IN_W - 1) - s, 24'd0};
          bit_idx <= 5'd23;
        end else begin
          w <= {w[LOG_IN_W-2:0], 1'b0};
          s <= s + 1'b1;
        end
      end
      LOG_SQUARE: begin
        if (t[LOG_M_W]) begin
          m               <= t[LOG_M_W:1];
          result[bit_idx] <= 1'b1;
        end else begin
          m <= t[LOG_M_W-1:0];
        end
        bit_idx <= bit_idx - 1'b1;
      end
      default: ;
    endcase
  end

  assign stat = '{busy: busy, done: done};

endmodule

>>> sv/ntc_thermistor_temperature_core.sv
// ----------------------------------------------------------------------------
// ntc_thermistor_temperature_core: burst-averaged NTC temperature sensor
// Averages ADC samples and converts them to millivolts and temperature.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one ADC sample per beat with its read_ok flag. Each
//   burst of burst-length beats (0 acts as 1, capped at MAX_SAMPLES)
//   yields one beat on out_ch: status, millivolts, temperature_centi.
//   Sample beats are taken only while the core is idle. After the last
//   beat of a burst the core stops taking samples while it converts: a
//   serial divider gives the average and the millivolts, a serial log2
//   unit (normalizing shifts, then one squaring per fraction bit)
//   handles both divider arms, and the divider gives the temperature.
//   Near-supply or near-ground results skip the log2 and temperature
//   steps; disabled or empty bursts skip the whole conversion.
//   The result sits in an output register, so a stalled receiver holds
//   only the next finished result; the core takes samples meanwhile.
//   Configuration writes (cfg_we, cfg_index, cfg_data) land at once and
//   belong between bursts. Synchronous reset clears the burst counters,
//   loads the register defaults and empties the output register.
// ----------------------------------------------------------------------------
module ntc_thermistor_temperature_core
  import ntc_pkg::*;
#(
  parameter int ADC_BITS    = 12,
  parameter int MAX_SAMPLES = 255
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ntc_in_if.sink                in_ch,
  ntc_out_if.source             out_ch
);

  localparam int SUM_W = ADC_BITS + 8;
  localparam int MVN_W = ADC_BITS + 14;
  localparam logic [ADC_BITS-1:0] FS = {ADC_BITS{1'b1}};

  // configuration registers
  logic        enabled;
  logic [7:0]  burst_len;
  logic [12:0] supply_millivolts;
  logic [19:0] fixed_resistor_ohms;
  logic [19:0] nominal_resistance_ohms;
  logic [13:0] beta_kelvin;

  // burst state
  logic [SUM_W-1:0] sample_sum;
  logic [7:0]       samples_seen;
  logic [7:0]       good_samples;

  ctrl_state_t state;
  ctrl_state_t state_next;

  logic in_ready;
  logic div_start;
  logic log_start;

  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] div_quo;
  unit_status_t         div_st;
  logic [LOG_IN_W-1:0]  log_x;
  logic [LOG_OUT_W-1:0] log_res;
  unit_status_t         log_st;

  logic [ADC_BITS-1:0]  avg;
  logic [12:0]          mv;
  logic [LOG_IN_W-1:0]  x1;
  logic [LOG_IN_W-1:0]  x2;
  logic [LOG_OUT_W-1:0] ra;
  logic [LOG_OUT_W-1:0] rb;
  logic                 l_neg;
  logic [LOG_OUT_W-1:0] mag;
  logic [LOG_OUT_W-1:0] lmag;
  logic signed [47:0]   den_s;
  logic [59:0]          num_t;

  status_t            res_status;
  logic [12:0]        res_mv;
  logic signed [15:0] res_temp;

  logic               out_valid;
  status_t            out_status;
  logic [12:0]        out_mv;
  logic signed [15:0] out_temp;

  // burst bookkeeping
  logic             in_fire;
  logic [7:0]       n_raw;
  logic [7:0]       n_eff;
  logic             burst_end;
  logic [SUM_W-1:0] sum_next;
  logic [7:0]       good_next;

  always_comb begin
    in_fire   = in_ch.valid && in_ready;
    n_raw     = (burst_len == 8'd0) ? 8'd1 : burst_len;
    n_eff     = (MAX_SAMPLES < int'(n_raw)) ? 8'(MAX_SAMPLES) : n_raw;
    burst_end = ({1'b0, samples_seen} + 9'd1) >= {1'b0, n_eff};
    sum_next  = sample_sum;
    good_next = good_samples;
    if (in_ch.read_ok) begin
      sum_next  = sample_sum + SUM_W'(in_ch.sample);
      good_next = good_samples + 8'd1;
    end
  end

  // datapath helpers
  logic [19:0]          rf_eff;
  logic [19:0]          r25_eff;
  logic [13:0]          b_eff;
  logic [MVN_W-1:0]     mv_num;
  logic signed [30:0]   d2;
  logic [62:0]          lprod;
  logic signed [47:0]   l_ext;
  logic signed [47:0]   den_calc;
  logic [35:0]          num_b;

  always_comb begin
    rf_eff   = (fixed_resistor_ohms == 20'd0) ? 20'd1 : fixed_resistor_ohms;
    r25_eff  = (nominal_resistance_ohms == 20'd0) ? 20'd1 : nominal_resistance_ohms;
    b_eff    = (beta_kelvin == 14'd0) ? 14'd1 : beta_kelvin;
    mv_num   = ((MVN_W'(avg) * MVN_W'(supply_millivolts)) << 1) + MVN_W'(FS);
    d2       = $signed({1'b0, ra}) - $signed({1'b0, rb});
    lprod    = (63'(mag) * 63'(LN2_Q32)) + 63'(64'h8000_0000);
    l_ext    = l_neg ? -$signed({18'd0, lmag}) : $signed({18'd0, lmag});
    den_calc = $signed({3'd0, 21'(B_SCALE_DEN * b_eff), 24'd0})
             + l_ext * 48'(T0_CENTI_B);
    num_b    = 36'(B_SCALE_NUM) * 36'(b_eff);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && burst_end) begin
          if (!enabled || good_next == 8'd0) state_next = ST_OUT;
          else                               state_next = ST_AVG_GO;
        end
      end
      ST_AVG_GO:   state_next = ST_AVG_WAIT;
      ST_AVG_WAIT: if (div_st.done) state_next = ST_MV_PREP;
      ST_MV_PREP:  state_next = ST_MV_GO;
      ST_MV_GO:    state_next = ST_MV_WAIT;
      ST_MV_WAIT:  if (div_st.done) state_next = ST_CHECK;
      ST_CHECK: begin
        if (mv == 13'd0 || ({1'b0, mv} + 14'd5) >= {1'b0, supply_millivolts}
            || mv <= 13'd5) state_next = ST_OUT;
        else                state_next = ST_LOGA_GO;
      end
      ST_LOGA_GO:   state_next = ST_LOGA_WAIT;
      ST_LOGA_WAIT: if (log_st.done) state_next = ST_LOGB_GO;
      ST_LOGB_GO:   state_next = ST_LOGB_WAIT;
      ST_LOGB_WAIT: if (log_st.done) state_next = ST_LN;
      ST_LN:        state_next = ST_LMUL;
      ST_LMUL:      state_next = ST_DEN;
      ST_DEN:       state_next = ST_NUM;
      ST_NUM:       state_next = (den_s <= 48'sd0) ? ST_OUT : ST_T_GO;
      ST_T_GO:      state_next = ST_T_WAIT;
      ST_T_WAIT:    if (div_st.done) state_next = ST_OUT;
      ST_OUT:       if (!out_valid || out_ch.ready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = (state == ST_IDLE);
    div_start = (state == ST_AVG_GO) || (state == ST_MV_GO) || (state == ST_T_GO);
    log_start = (state == ST_LOGA_GO) || (state == ST_LOGB_GO);
    log_x     = (state == ST_LOGA_GO) ? x1 : x2;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state                   <= ST_IDLE;
      enabled                 <= 1'b0;
      burst_len               <= 8'd16;
      supply_millivolts       <= 13'd3300;
      fixed_resistor_ohms     <= 20'd10000;
      nominal_resistance_ohms <= 20'd10000;
      beta_kelvin             <= 14'd3950;
      sample_sum              <= '0;
      samples_seen            <= '0;
      good_samples            <= '0;
      out_valid               <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ENABLED:      enabled                 <= cfg_data[0];
          REG_BURST_LEN:    burst_len               <= cfg_data[7:0];
          REG_SUPPLY_MV:    supply_millivolts       <= cfg_data[12:0];
          REG_FIXED_OHMS:   fixed_resistor_ohms     <= cfg_data[19:0];
          REG_NOMINAL_OHMS: nominal_resistance_ohms <= cfg_data[19:0];
          REG_BETA:         beta_kelvin             <= cfg_data[13:0];
          default: ;
        endcase
      end
      // accumulate, clear at burst end
      if (in_fire) begin
        if (burst_end) begin
          sample_sum   <= '0;
          samples_seen <= '0;
          good_samples <= '0;
        end else begin
          sample_sum   <= sum_next;
          samples_seen <= samples_seen + 8'd1;
          good_samples <= good_next;
        end
      end
      // output register
      if (state == ST_OUT && (!out_valid || out_ch.ready)) out_valid <= 1'b1;
      else if (out_ch.ready)                                out_valid <= 1'b0;
    end
  end

  // conversion datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        res_mv   <= '0;
        res_temp <= '0;
        div_num  <= DIV_NUM_W'(sum_next);
        div_den  <= DIV_DEN_W'(good_next);
        res_status <= enabled ? STAT_NO_DATA : STAT_DISABLED;
      end
      ST_AVG_WAIT: if (div_st.done) avg <= div_quo[ADC_BITS-1:0];
      ST_MV_PREP: begin
        div_num <= DIV_NUM_W'(mv_num);
        div_den <= DIV_DEN_W'({FS, 1'b0});
      end
      ST_MV_WAIT: if (div_st.done) mv <= div_quo[12:0];
      ST_CHECK: begin
        res_mv <= mv;
        if (mv == 13'd0)
          res_status <= STAT_NEAR_GROUND;
        else if (({1'b0, mv} + 14'd5) >= {1'b0, supply_millivolts})
          res_status <= STAT_NEAR_SUPPLY;
        else if (mv <= 13'd5)
          res_status <= STAT_NEAR_GROUND;
        else
          res_status <= STAT_OK;
        x1 <= LOG_IN_W'(rf_eff) * LOG_IN_W'(mv);
        x2 <= LOG_IN_W'(supply_millivolts - mv) * LOG_IN_W'(r25_eff);
      end
      ST_LOGA_WAIT: if (log_st.done) ra <= log_res;
      ST_LOGB_WAIT: if (log_st.done) rb <= log_res;
      ST_LN: begin
        l_neg <= d2[30];
        mag   <= d2[30] ? LOG_OUT_W'(-d2) : LOG_OUT_W'(d2);
      end
      ST_LMUL: lmag <= lprod[61:32];
      ST_DEN: begin
        den_s <= den_calc;
        num_t <= {num_b, 24'd0};
      end
      ST_NUM: begin
        if (den_s <= 48'sd0) res_temp <= 16'sh8000;
        div_num <= DIV_NUM_W'(num_t) + DIV_NUM_W'(den_s[46:1]);
        div_den <= den_s[46:0];
      end
      ST_T_WAIT: begin
        if (div_st.done) begin
          if (div_quo > DIV_NUM_W'(TEMP_MAX_Q)) res_temp <= 16'sh7FFF;
          else res_temp <= $signed(div_quo[15:0] - 16'(KELVIN_CENTI));
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ch.ready) begin
          out_status <= res_status;
          out_mv     <= res_mv;
          out_temp   <= res_temp;
        end
      end
      default: ;
    endcase
  end

  ntc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_st),
    .quo   (div_quo)
  );

  ntc_log2 u_log (
    .clk    (clk),
    .rst    (rst),
    .start  (log_start),
    .x      (log_x),
    .stat   (log_st),
    .result (log_res)
  );

  assign in_ch.ready              = in_ready;
  assign out_ch.valid             = out_valid;
  assign out_ch.status            = out_status;
  assign out_ch.millivolts        = out_mv;
  assign out_ch.temperature_centi = out_temp;

  // a shared unit is never kicked while it is still running
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_st.busy)
    else $error("divider started while busy");

  a_log_idle: assert property (@(posedge clk) disable iff (rst)
    log_start |-> !log_st.busy)
    else $error("log2 unit started while busy");

  // the last beat of a burst leaves the idle state
  a_burst_leave: assert property (@(posedge clk) disable iff (rst)
    (in_fire && burst_end) |=> (state != ST_IDLE))
    else $error("burst end did not start a conversion");

  // an ok result always carries a voltage clear of ground
  a_ok_mv: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == STAT_OK) |-> (out_mv > 13'd5))
    else $error("ok status with voltage near ground");

  // disabled or empty bursts report zero voltage and temperature
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status == STAT_DISABLED || out_status == STAT_NO_DATA))
      |-> (out_mv == 13'd0 && out_temp == 16'sd0))
    else $error("empty burst result not zero");

endmodule
